// File: rtl/core/afb_pkg.sv
`timescale 1ns / 1ps
// package: shared types, codes, constants and the sigmoid sample table
package afb_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int SAMPLE_WIDTH  = 31;
  localparam int SAMPLE_FRAC   = 30;
  localparam int INDEX_WIDTH   = 9;
  localparam int SPAN_WIDTH    = 8;

  typedef enum logic [2:0] {
    KIND_NULL    = 3'd0,
    KIND_LINEAR  = 3'd1,
    KIND_SIGMOID = 3'd2,
    KIND_TANH    = 3'd3,
    KIND_RELU    = 3'd4,
    KIND_LEAKY   = 3'd5
  } kind_t;

  localparam logic CMD_FORWARD  = 1'b0;
  localparam logic CMD_BACKWARD = 1'b1;

  localparam logic [0:0] REG_KIND  = 1'b0;
  localparam logic [0:0] REG_SLOPE = 1'b1;

  localparam logic [15:0] LEAK_SLOPE_RESET = 16'd655;

  // sigmoid argument offset and span in Q4.12
  localparam logic signed [17:0] SIG_OFFSET = 18'(8 << FRAC_BITS);
  localparam logic signed [17:0] SIG_LIMIT  = 18'(16 << FRAC_BITS);
  localparam logic signed [16:0] ONE_Q      = 17'(1 << FRAC_BITS);
  localparam logic signed [32:0] HALF_LSB   = 33'(1 << (FRAC_BITS - 1));

  localparam logic [63:0] EXP_MINUS_ONE_Q32 = 64'd1580030169;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [TABLE_ENTRIES:0][SAMPLE_WIDTH-1:0] sig_table_t;

  typedef struct packed {
    logic                  command;
    data_t                 value;
    data_t                 delta;
    sample_t               base;
    sample_t               step;
    logic [SPAN_WIDTH-1:0] frac;
    logic signed [32:0]    fprod;
  } s1_t;

  typedef struct packed {
    logic               command;
    data_t              value;
    data_t              delta;
    sample_t            base;
    sample_t            interp;
    data_t              grad;
    logic               grad_sat;
    logic signed [32:0] lprod;
  } s2_t;

  typedef struct packed {
    logic               command;
    data_t              value;
    data_t              delta;
    data_t              act;
    logic signed [31:0] gprod;
    logic               grad_sat;
    logic signed [16:0] leak;
  } s3_t;

  // sample k = sigmoid(-8 + 16k/N) in Q0.30, exp(-t) from exp(-1)^floor(t)
  // times a 20-term series of the fraction, all Q32 with truncation
  function automatic sig_table_t build_sig_table();
    sig_table_t        tbl;
    logic [63:0]       a;
    logic [63:0]       tq;
    logic [63:0]       ti;
    logic [63:0]       f;
    logic [63:0]       term;
    logic [63:0]       den;
    logic [63:0]       num;
    logic [63:0]       quo;
    logic [63:0]       rem;
    logic signed [63:0] sum;
    int                k;
    int                n;
    int                i;
    int                j;
    tbl = '0;
    for (k = 0; k <= TABLE_ENTRIES; k++) begin
      if (16 * k >= 8 * TABLE_ENTRIES) begin
        a = 64'(16 * k - 8 * TABLE_ENTRIES);
      end else begin
        a = 64'(8 * TABLE_ENTRIES - 16 * k);
      end
      tq   = (a << 32) / TABLE_ENTRIES;
      ti   = tq >> 32;
      f    = tq & 64'h0000_0000_FFFF_FFFF;
      sum  = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (n = 1; n <= 20; n++) begin
        term = (term * f) >> 32;
        // long division of term by the term index
        rem = '0;
        quo = '0;
        for (j = 63; j >= 0; j--) begin
          rem = {rem[62:0], term[j]};
          if (rem >= 64'(n)) begin
            rem    = rem - 64'(n);
            quo[j] = 1'b1;
          end
        end
        term = quo;
        if ((n & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      for (i = 0; i < int'(ti); i++) begin
        sum = $signed(($unsigned(sum) * EXP_MINUS_ONE_Q32) >> 32);
      end
      den = 64'h1_0000_0000 + $unsigned(sum);
      num = (64'd1 << 62) + (den >> 1);
      rem = '0;
      quo = '0;
      for (j = 63; j >= 0; j--) begin
        rem = {rem[62:0], num[j]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[j] = 1'b1;
        end
      end
      if (16 * k >= 8 * TABLE_ENTRIES) begin
        tbl[k] = quo[SAMPLE_WIDTH-1:0];
      end else begin
        tbl[k] = SAMPLE_WIDTH'((64'd1 << SAMPLE_FRAC) - quo);
      end
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// File: rtl/core/activation_forward_backward_unit_top.sv
`timescale 1ns / 1ps
// top level: elementwise activation and gradient unit, four stage pipeline
// Elementwise activation unit in signed Q4.12. Each input transfer carries a
// command (forward or backward), a value and a delta; each produces exactly one
// output transfer with a result and a saturated flag. Forward returns f(value)
// for the configured kind (null, linear, sigmoid, tanh, relu, leaky relu);
// backward returns delta * f'(value), where value is the cached input for the
// relu kinds and the cached output for sigmoid and tanh. Sigmoid comes from a
// 257-sample constant table over [-8,8] with linear interpolation, tanh from
// 2*sigmoid(2x)-1. Kinds 6 and 7 pass the value (or delta) through. The unit
// takes one transfer per clock while the output is not held off and has four
// register stages: stage 1 fetches the table samples and forms the derivative
// product, stage 2 interpolates and clips the derivative factor, stage 3 rounds
// and forms delta times the factor, stage 4 selects, clips and holds the result
// in the output register. Each stage advances when it is empty or the next one
// advances, so empty slots are squeezed out and input keeps flowing while a
// finished result waits. Write activation_kind (index 0) and leak_slope
// (index 1, unsigned Q0.16) only while no transfer is in flight.
module activation_forward_backward_unit_top
  import afb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  data_t       value,
  input  data_t       delta,
  output logic        out_valid,
  input  logic        out_ready,
  output data_t       result,
  output logic        saturated
);

  // configuration registers
  logic [2:0]  kind;
  logic [15:0] slope;

  // stage valids and load enables
  logic v1;
  logic v2;
  logic v3;
  logic en1;
  logic en2;
  logic en3;
  logic en4;

  s1_t s1;
  s2_t s2;
  s3_t s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= KIND_NULL;
      slope <= LEAK_SLOPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KIND:  kind  <= cfg_data[2:0];
        REG_SLOPE: slope <= cfg_data;
        default:   ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor loads
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // table fetch and derivative product
  afb_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en1),
    .in_valid  (in_valid),
    .command   (command),
    .value     (value),
    .delta     (delta),
    .kind      (kind),
    .out_valid (v1),
    .s1        (s1)
  );

  // interpolation, factor clip, leak product
  afb_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .in_valid  (v1),
    .s1        (s1),
    .kind      (kind),
    .slope     (slope),
    .out_valid (v2),
    .s2        (s2)
  );

  // rounding and gradient product
  afb_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en3),
    .in_valid  (v2),
    .s2        (s2),
    .kind      (kind),
    .out_valid (v3),
    .s3        (s3)
  );

  // select, clip, output register
  afb_select u_select (
    .clk       (clk),
    .rst       (rst),
    .en        (en4),
    .in_valid  (v3),
    .s3        (s3),
    .kind      (kind),
    .out_valid (out_valid),
    .result    (result),
    .saturated (saturated)
  );

  // an accepted transfer always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted transfer did not reach stage 1");

  // a held stage keeps its item and payload
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(s2))
    else $error("stage 2 lost or changed a held item");

  // only backward sigmoid or tanh can clip
  a_sat_source: assert property (@(posedge clk) disable iff (rst)
    en4 && v3 && (s3.command == CMD_FORWARD ||
                  (kind != KIND_SIGMOID && kind != KIND_TANH)) |=> !saturated)
    else $error("saturation flagged on a path that cannot clip");

endmodule

// File: rtl/core/afb_lookup.sv
`timescale 1ns / 1ps
// stage 1: sigmoid sample fetch and derivative factor product
module afb_lookup
  import afb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic       command,
  input  data_t      value,
  input  data_t      delta,
  input  logic [2:0] kind,
  output logic       out_valid,
  output s1_t        s1
);

  logic signed [16:0]     arg;
  logic signed [17:0]     pos;
  logic                   below;
  logic                   above;
  logic [INDEX_WIDTH-1:0] addr_lo;
  logic [INDEX_WIDTH-1:0] addr_hi;
  sample_t                samp_lo;
  sample_t                samp_hi;
  logic signed [16:0]     m_op;
  logic signed [32:0]     v_ext;
  logic signed [32:0]     m_ext;
  logic signed [32:0]     fprod;

  always_comb begin
    // tanh looks up sigmoid at twice the argument
    if (kind == KIND_TANH) begin
      arg = {value, 1'b0};
    end else begin
      arg = {value[DATA_WIDTH-1], value};
    end
    pos   = {arg[16], arg} + SIG_OFFSET;
    below = (pos <= 18'sd0);
    above = (pos >= SIG_LIMIT);
    // upper byte of the offset argument picks the sample, lower byte interpolates
    if (below) begin
      addr_lo = '0;
    end else if (above) begin
      addr_lo = INDEX_WIDTH'(TABLE_ENTRIES);
    end else begin
      addr_lo = {1'b0, pos[15:8]};
    end
    addr_hi = {1'b0, pos[15:8]} + 9'd1;
    samp_lo = SIG_TABLE[addr_lo];
    samp_hi = SIG_TABLE[addr_hi];

    // v*v for tanh, v*(1-v) otherwise
    if (kind == KIND_TANH) begin
      m_op = {value[DATA_WIDTH-1], value};
    end else begin
      m_op = ONE_Q - {value[DATA_WIDTH-1], value};
    end
    v_ext = {{17{value[DATA_WIDTH-1]}}, value};
    m_ext = {{16{m_op[16]}}, m_op};
    fprod = v_ext * m_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.command <= command;
      s1.value   <= value;
      s1.delta   <= delta;
      s1.base    <= samp_lo;
      s1.step    <= (!below && !above && samp_hi > samp_lo) ? samp_hi - samp_lo : '0;
      s1.frac    <= pos[SPAN_WIDTH-1:0];
      s1.fprod   <= fprod;
    end
  end

endmodule

// File: rtl/core/afb_interp.sv
`timescale 1ns / 1ps
// stage 2: interpolation product, derivative factor clip, leak product
module afb_interp
  import afb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  s1_t         s1,
  input  logic [2:0]  kind,
  input  logic [15:0] slope,
  output logic        out_valid,
  output s2_t         s2
);

  logic [38:0]        iprod;
  logic signed [32:0] fsum;
  logic signed [20:0] fround;
  logic signed [21:0] graw;
  data_t              gclip;
  logic               gsat;
  logic signed [32:0] x_ext;
  logic signed [32:0] s_ext;
  logic signed [32:0] lprod;

  always_comb begin
    iprod  = {8'b0, s1.step} * {31'b0, s1.frac};
    fsum   = s1.fprod + HALF_LSB;
    fround = fsum[32:12];
    if (kind == KIND_TANH) begin
      graw = {ONE_Q[16], ONE_Q[16], ONE_Q[16], ONE_Q[16], ONE_Q[16], ONE_Q}
             - {fround[20], fround};
    end else begin
      graw = {fround[20], fround};
    end
    gsat = 1'b0;
    if (graw > 22'sd32767) begin
      gclip = 16'sh7FFF;
      gsat  = 1'b1;
    end else if (graw < -22'sd32768) begin
      gclip = 16'sh8000;
      gsat  = 1'b1;
    end else begin
      gclip = graw[DATA_WIDTH-1:0];
    end

    // leak slope applies to the gradient going back, to the input going forward
    if (s1.command == CMD_BACKWARD) begin
      x_ext = {{17{s1.delta[DATA_WIDTH-1]}}, s1.delta};
    end else begin
      x_ext = {{17{s1.value[DATA_WIDTH-1]}}, s1.value};
    end
    s_ext = {17'b0, slope};
    lprod = x_ext * s_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.command  <= s1.command;
      s2.value    <= s1.value;
      s2.delta    <= s1.delta;
      s2.base     <= s1.base;
      s2.interp   <= iprod[38:8];
      s2.grad     <= gclip;
      s2.grad_sat <= gsat;
      s2.lprod    <= lprod;
    end
  end

endmodule

// File: rtl/core/afb_round.sv
`timescale 1ns / 1ps
// stage 3: forward activation rounding, gradient product, leak rounding
module afb_round
  import afb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  s2_t        s2,
  input  logic [2:0] kind,
  output logic       out_valid,
  output s3_t        s3
);

  sample_t            y;
  logic [31:0]        ysum;
  logic [32:0]        tsum;
  data_t              act;
  logic signed [31:0] d_ext;
  logic signed [31:0] g_ext;
  logic signed [31:0] gprod;
  logic signed [32:0] lsum;

  always_comb begin
    y    = s2.base + s2.interp;
    // Q0.30 to Q4.12, round half up
    ysum = {1'b0, y} + 32'd131072;
    tsum = {1'b0, y, 1'b0} - 33'd1073741824 + 33'd131072;
    if (kind == KIND_TANH) begin
      act = {tsum[32], tsum[32:18]};
    end else begin
      act = {2'b0, ysum[31:18]};
    end
    d_ext = {{16{s2.delta[DATA_WIDTH-1]}}, s2.delta};
    g_ext = {{16{s2.grad[DATA_WIDTH-1]}}, s2.grad};
    gprod = d_ext * g_ext;
    lsum  = s2.lprod + 33'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.command  <= s2.command;
      s3.value    <= s2.value;
      s3.delta    <= s2.delta;
      s3.act      <= act;
      s3.gprod    <= gprod;
      s3.grad_sat <= s2.grad_sat;
      s3.leak     <= lsum[32:16];
    end
  end

endmodule

// File: rtl/core/afb_select.sv
`timescale 1ns / 1ps
// stage 4: result select, final clip and output register
module afb_select
  import afb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  s3_t        s3,
  input  logic [2:0] kind,
  output logic       out_valid,
  output data_t      result,
  output logic       saturated
);

  localparam logic signed [21:0] PICK_MAX = 22'sd32767;
  localparam logic signed [21:0] PICK_MIN = -22'sd32768;

  logic signed [32:0] bsum;
  logic signed [20:0] bround;
  logic signed [21:0] pick;
  logic signed [21:0] v_wide;
  logic signed [21:0] d_wide;
  logic signed [21:0] l_wide;
  logic               pos_val;
  logic               pick_sat;
  data_t              res;
  logic               sat;

  always_comb begin
    bsum    = {s3.gprod[31], s3.gprod} + HALF_LSB;
    bround  = bsum[32:12];
    v_wide  = {{6{s3.value[DATA_WIDTH-1]}}, s3.value};
    d_wide  = {{6{s3.delta[DATA_WIDTH-1]}}, s3.delta};
    l_wide  = {{5{s3.leak[16]}}, s3.leak};
    // zero counts as non-positive
    pos_val = !s3.value[DATA_WIDTH-1] && (s3.value != '0);
    pick_sat = 1'b0;
    if (s3.command == CMD_FORWARD) begin
      case (kind)
        KIND_SIGMOID, KIND_TANH: pick = {{6{s3.act[DATA_WIDTH-1]}}, s3.act};
        KIND_RELU:               pick = pos_val ? v_wide : '0;
        KIND_LEAKY:              pick = pos_val ? v_wide : l_wide;
        default:                 pick = v_wide;
      endcase
    end else begin
      case (kind)
        KIND_SIGMOID, KIND_TANH: begin
          pick     = {bround[20], bround};
          pick_sat = s3.grad_sat;
        end
        KIND_RELU:               pick = pos_val ? d_wide : '0;
        KIND_LEAKY:              pick = pos_val ? d_wide : l_wide;
        default:                 pick = d_wide;
      endcase
    end
    sat = pick_sat;
    if (pick > PICK_MAX) begin
      res = 16'sh7FFF;
      sat = 1'b1;
    end else if (pick < PICK_MIN) begin
      res = 16'sh8000;
      sat = 1'b1;
    end else begin
      res = pick[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result    <= res;
      saturated <= sat;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: activation and gradient unit against its own bit-true predictor
module testbench
  import afb_pkg::*;
();

  // kinds 6 and 7 have no name in the package and act as pass-through
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam int     SLOPE_FRAC = 16;
  localparam longint Q_ONE      = 64'sd1 <<< FRAC_BITS;
  localparam longint Q30_ONE    = 64'sd1 <<< SAMPLE_FRAC;
  localparam longint Q_MAX      = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint Q_MIN      = -(64'sd1 <<< (DATA_WIDTH - 1));
  localparam longint unsigned E_INV_Q32 = 64'd1580030169;  // exp(-1) in Q32

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    data_t result;
    logic  saturated;
  } result_t;

  // one row of the directed table; want is used only when given is set
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] slope;
    logic        cmd;
    data_t       value;
    data_t       delta;
    logic        given;
    data_t       want;
    logic        want_sat;
  } directed_step_t;

  // dut ports, all driven to known values from time zero
  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = REG_KIND;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        command   = CMD_FORWARD;
  data_t       value     = '0;
  data_t       delta     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  data_t       result;
  logic        saturated;

  // predictor copy of the two registers
  logic [2:0]  unit_kind  = KIND_NULL;
  logic [15:0] unit_slope = LEAK_SLOPE_RESET;

  // sigmoid samples in Q0.30, rebuilt here independently of the package table
  longint unsigned sigmoid_q30_samples [TABLE_ENTRIES+1];

  result_t        awaited_results [$];
  directed_step_t directed_steps [$];

  // idle odds in percent for each side
  int send_idle_pct  = 0;
  int take_stall_pct = 0;

  int mismatches       = 0;
  int forward_count    = 0;
  int backward_count   = 0;
  int clipped_seen     = 0;
  int settings_visited = 0;

  activation_forward_backward_unit_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .delta     (delta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .saturated (saturated)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // sample k = sigmoid(-8 + 16k/N): exp(-t) as exp(-1)^floor(t) times a
  // 20-term series of the fraction, all Q32 with truncation
  initial begin : build_sigmoid_samples
    longint          num;
    longint          sum;
    longint unsigned mag;
    longint unsigned tq;
    longint unsigned frac;
    longint unsigned term;
    longint unsigned den;
    longint unsigned sp;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      num  = 16 * k - 8 * TABLE_ENTRIES;
      mag  = (num < 0) ? -num : num;
      tq   = (mag << 32) / TABLE_ENTRIES;
      frac = tq & 64'h0000_0000_FFFF_FFFF;
      sum  = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (int n = 1; n <= 20; n++) begin
        term = (term * frac) >> 32;
        term = term / $unsigned(64'(n));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      for (longint unsigned i = 0; i < (tq >> 32); i++) begin
        sum = $signed(($unsigned(sum) * E_INV_Q32) >> 32);
      end
      den = 64'h1_0000_0000 + $unsigned(sum);
      sp  = (64'h4000_0000_0000_0000 + den / 2) / den;
      sigmoid_q30_samples[k] = (num >= 0) ? sp : (64'd1 << SAMPLE_FRAC) - sp;
    end
  end

  // floor((v + 2^(s-1)) / 2^s): round to nearest, ties up
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // sigmoid of a Q.FRAC_BITS argument in Q0.30, truncating interpolation
  function automatic longint sigmoid_q30(longint x);
    longint          u;
    longint unsigned scaled;
    longint unsigned idx;
    longint unsigned fr;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned y;
    u = x + (64'sd8 <<< FRAC_BITS);
    if (u <= 0) return $signed(sigmoid_q30_samples[0]);
    if (u >= (64'sd16 <<< FRAC_BITS)) return $signed(sigmoid_q30_samples[TABLE_ENTRIES]);
    scaled = $unsigned(u) * TABLE_ENTRIES;
    idx    = scaled >> (FRAC_BITS + 4);
    fr     = scaled & ((64'd1 << (FRAC_BITS + 4)) - 1);
    lo     = sigmoid_q30_samples[idx];
    hi     = sigmoid_q30_samples[idx + 1];
    y      = lo;
    if (hi > lo) y = y + (((hi - lo) * fr) >> (FRAC_BITS + 4));
    return $signed(y);
  endfunction

  // f(value) on forward, delta * f'(value) on backward, for the current kind
  function automatic result_t activate_or_backprop(logic cmd, data_t v_in, data_t d_in);
    longint  v;
    longint  d;
    longint  g;
    longint  r;
    bit      clipped;
    result_t res;
    v       = v_in;
    d       = d_in;
    g       = 0;
    r       = v;
    clipped = 1'b0;
    if (cmd == CMD_FORWARD) begin
      case (unit_kind)
        KIND_SIGMOID: r = round_shift(sigmoid_q30(v), SAMPLE_FRAC - FRAC_BITS);
        KIND_TANH: r = round_shift(2 * sigmoid_q30(2 * v) - Q30_ONE, SAMPLE_FRAC - FRAC_BITS);
        KIND_RELU: r = (v > 0) ? v : 0;
        KIND_LEAKY: r = (v > 0) ? v : round_shift(v * longint'(unit_slope), SLOPE_FRAC);
        default: r = v;
      endcase
    end else begin
      case (unit_kind)
        KIND_SIGMOID, KIND_TANH: begin
          if (unit_kind == KIND_SIGMOID) begin
            g = round_shift(v * (Q_ONE - v), FRAC_BITS);
          end else begin
            g = Q_ONE - round_shift(v * v, FRAC_BITS);
          end
          clipped = (g > Q_MAX) || (g < Q_MIN);
          r = round_shift(d * clamp_q(g), FRAC_BITS);
        end
        KIND_RELU: r = (v > 0) ? d : 0;
        KIND_LEAKY: r = (v > 0) ? d : round_shift(d * longint'(unit_slope), SLOPE_FRAC);
        default: r = d;
      endcase
    end
    clipped       = clipped || (r > Q_MAX) || (r < Q_MIN);
    res.result    = data_t'(clamp_q(r));
    res.saturated = clipped;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  function automatic void add_step(logic [2:0] kind, logic [15:0] slope, logic cmd,
                                   data_t v, data_t d, logic given, data_t want,
                                   logic want_sat);
    directed_step_t st;
    st.kind     = kind;
    st.slope    = slope;
    st.cmd      = cmd;
    st.value    = v;
    st.delta    = d;
    st.given    = given;
    st.want     = want;
    st.want_sat = want_sat;
    directed_steps.push_back(st);
  endfunction

  // full range a third of the time, else the output ranges, values near zero and corners
  function automatic data_t pick_q412();
    case ($urandom_range(0, 5))
      1: return data_t'(int'($urandom_range(0, 8192)) - 4096);
      2: return data_t'($urandom_range(0, 4096));
      3: return data_t'(int'($urandom_range(0, 32)) - 16);
      4: begin
        case ($urandom_range(0, 6))
          0: return 16'sh8000;
          1: return 16'sh8001;
          2: return 16'shFFFF;
          3: return 16'sh0000;
          4: return 16'sh0001;
          5: return 16'sh1000;
          default: return 16'sh7FFF;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // one input transfer with random leading gaps; the expectation is queued at
  // the accepting edge, either typed in or from the predictor
  task automatic offer_item(input logic cmd, input data_t v, input data_t d,
                            input logic given, input result_t given_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    delta    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (given) begin
      awaited_results.push_back(given_res);
    end else begin
      awaited_results.push_back(activate_or_backprop(cmd, v, d));
    end
    if (cmd == CMD_FORWARD) forward_count++;
    else backward_count++;
  endtask

  // stop offering and wait until every result is back; every transfer yields
  // one result, so an empty queue means an empty pipeline
  task automatic drain_in_flight();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // both registers on back-to-back edges, only while the unit is idle
  task automatic apply_setting(input logic [2:0] kind, input logic [15:0] slope);
    cfg_write <= 1'b1;
    cfg_index <= REG_KIND;
    cfg_data  <= 16'(kind);
    @(posedge clk);
    cfg_index <= REG_SLOPE;
    cfg_data  <= slope;
    @(posedge clk);
    cfg_write  <= 1'b0;
    unit_kind  = kind;
    unit_slope = slope;
    settings_visited++;
  endtask

  // output side: check each transfer against the oldest expectation, then
  // decide the next out_ready with the current stall odds
  always @(posedge clk) begin : take_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing outstanding", result));
      end else begin
        want = awaited_results.pop_front();
        if (result !== want.result) begin
          flag_mismatch($sformatf("result %h, predicted %h (kind %0d)",
                                  result, want.result, unit_kind));
        end
        if (saturated !== want.saturated) begin
          flag_mismatch($sformatf("saturated %b, predicted %b (result %h, kind %0d)",
                                  saturated, want.saturated, result, unit_kind));
        end
      end
      if (saturated === 1'b1) clipped_seen++;
    end
    out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  initial begin : stimulus
    directed_step_t st;
    result_t        given_res;
    logic [2:0]     kind;
    logic [15:0]    slope;

    // directed table: corners of each field, every kind and both commands;
    // expected values typed in where they follow directly from the arithmetic
    // pass-through kinds at the reset setting
    add_step(KIND_NULL, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh7FFF, 16'sh0000,
             1'b1, 16'sh7FFF, 1'b0);
    add_step(KIND_NULL, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh1234, 16'sh8000,
             1'b1, 16'sh8000, 1'b0);
    add_step(KIND_LINEAR, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh8000, 16'sh7FFF,
             1'b1, 16'sh8000, 1'b0);
    add_step(KIND_LINEAR, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh8000, 16'sh7FFF,
             1'b1, 16'sh7FFF, 1'b0);
    // relu: zero counts as non-positive
    add_step(KIND_RELU, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh0000, 16'sh7FFF,
             1'b1, 16'sh0000, 1'b0);
    add_step(KIND_RELU, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh8000, 16'sh0000,
             1'b1, 16'sh0000, 1'b0);
    add_step(KIND_RELU, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0000, 16'sh1234,
             1'b1, 16'sh0000, 1'b0);
    add_step(KIND_RELU, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0001, 16'sh8000,
             1'b1, 16'sh8000, 1'b0);
    // leaky relu at the default, largest and zero slopes
    add_step(KIND_LEAKY, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh8000, 16'sh0000,
             1'b1, data_t'(-327), 1'b0);
    add_step(KIND_LEAKY, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0000, 16'sh7FFF,
             1'b0, '0, 1'b0);
    add_step(KIND_LEAKY, 16'hFFFF, CMD_FORWARD, 16'sh8000, 16'sh0000,
             1'b1, data_t'(-32767), 1'b0);
    add_step(KIND_LEAKY, 16'hFFFF, CMD_BACKWARD, 16'sh8000, 16'sh8000,
             1'b1, data_t'(-32767), 1'b0);
    add_step(KIND_LEAKY, 16'h0000, CMD_FORWARD, 16'shFFFF, 16'sh0000,
             1'b1, 16'sh0000, 1'b0);
    // sigmoid: both table ends, the midpoint, derivative factor clipping
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh8000, 16'sh0000,
             1'b0, '0, 1'b0);
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh7FFF, 16'sh0000,
             1'b0, '0, 1'b0);
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh0000, 16'sh0000,
             1'b1, 16'sh0800, 1'b0);
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0800, 16'sh1000,
             1'b1, 16'sh0400, 1'b0);
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh8000, 16'sh0001,
             1'b1, data_t'(-8), 1'b1);
    add_step(KIND_SIGMOID, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh7FFF, 16'sh7FFF,
             1'b1, 16'sh8000, 1'b1);
    // tanh: zero, doubled argument below the table, factor and result clipping
    add_step(KIND_TANH, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh0000, 16'sh0000,
             1'b1, 16'sh0000, 1'b0);
    add_step(KIND_TANH, LEAK_SLOPE_RESET, CMD_FORWARD, 16'sh8000, 16'sh0000,
             1'b0, '0, 1'b0);
    add_step(KIND_TANH, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0000, 16'sh7FFF,
             1'b1, 16'sh7FFF, 1'b0);
    add_step(KIND_TANH, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh8000, 16'sh8000,
             1'b1, 16'sh7FFF, 1'b1);
    // unnamed kinds pass through
    add_step(KIND_SPARE_7, LEAK_SLOPE_RESET, CMD_FORWARD, 16'shFFFF, 16'sh0000,
             1'b1, 16'shFFFF, 1'b0);
    add_step(KIND_SPARE_6, LEAK_SLOPE_RESET, CMD_BACKWARD, 16'sh0000, 16'sh5555,
             1'b1, 16'sh5555, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // first idling mode: sender rarely idles, receiver stalls about half the time
    send_idle_pct  = 19;
    take_stall_pct = 51;

    // directed part; the register setting changes only between drained rows
    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.kind != unit_kind || st.slope != unit_slope) begin
        drain_in_flight();
        apply_setting(st.kind, st.slope);
      end
      given_res.result    = st.want;
      given_res.saturated = st.want_sat;
      offer_item(st.cmd, st.value, st.delta, st.given, given_res);
    end

    // random part: one register setting per phase, idling mode per third
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle_pct  = 51;
        take_stall_pct = 19;
      end else if (p == 2 * PHASES / 3) begin
        send_idle_pct  = 0;
        take_stall_pct = 0;
      end
      case (p)
        0, 6: kind = KIND_SIGMOID;
        1, 7: kind = KIND_TANH;
        2, 4, 8: kind = KIND_LEAKY;
        3: kind = KIND_RELU;
        5: kind = KIND_NULL;
        9: kind = KIND_LINEAR;
        10: kind = KIND_SPARE_6;
        default: kind = KIND_SPARE_7;
      endcase
      // slope extremes on two leaky phases, random elsewhere
      if (p == 2) slope = 16'h0000;
      else if (p == 4) slope = 16'hFFFF;
      else slope = 16'($urandom_range(0, 65535));
      drain_in_flight();
      apply_setting(kind, slope);
      repeat (PHASE_ITEMS) begin
        offer_item(($urandom_range(0, 1) == 1) ? CMD_BACKWARD : CMD_FORWARD,
                   pick_q412(), pick_q412(), 1'b0, '0);
      end
    end

    // wait out everything in flight, then keep clocking so any stray result is seen
    drain_in_flight();
    repeat (16) @(posedge clk);

    $display("covered %0d transfers (%0d forward, %0d backward) under %0d register settings",
             forward_count + backward_count, forward_count, backward_count,
             settings_visited);
    $display("%0d results came back clipped, %0d mismatches", clipped_seen, mismatches);
    if (mismatches == 0) begin
      $display("** activation_forward_backward_unit_top: PASSED **");
    end else begin
      $display("** activation_forward_backward_unit_top: FAILED **");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("** activation_forward_backward_unit_top: FAILED **");
    $finish;
  end

endmodule
